>>> src/glpb_pkg.sv
// glpb_pkg: shared widths, constants and register codes of the
// height map low point and basin core; no dependencies
`default_nettype none
package glpb_pkg;
  localparam int HEIGHT_W   = 4;
  localparam int RISK_W     = 18;
  localparam int PROD_W     = 43;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;

  localparam logic [HEIGHT_W-1:0] BORDER_HEIGHT = 4'd9;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 4'd1;
endpackage
`default_nettype wire

>>> src/glpb_ram.sv
// glpb_ram: generic simple dual port RAM, one write and one registered read
// no dependencies
`default_nettype none
module glpb_ram #(
  parameter int WIDTH  = 4,
  parameter int DEPTH  = 16384,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> src/grid_low_points_and_basins_core.sv
// grid_low_points_and_basins_core: top level of the height map core
// depends on glpb_pkg and glpb_ram
`default_nettype none
// Loads a height map of digits one word per cycle while in_ready is high (in
// S_LOAD), in row-major order, into a height RAM, then on the word marked
// last_cell finds the low points (risk sum) and walks every non-9 cell down
// its first strictly lower neighbour (left, right, up, down) to a sink,
// counting basin sizes in a count RAM. One result word carries the risk sum
// and the product of the TOP_COUNT largest basins. The analysis is set by the
// single read port of the height RAM: each walk step is 5 reads plus an
// evaluate, each non-9 cell ends in a count read and write, and a final scan
// of the counts plus one multiply per kept basin forms the product. After
// reset a clearing pass over all MAX_WIDTH*MAX_HEIGHT entries zeroes the count
// RAM before the first word is taken; the scan re-zeroes each map's entries.
module grid_low_points_and_basins_core #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128,
  parameter int TOP_COUNT  = 3
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [glpb_pkg::HEIGHT_W-1:0]     cell_height,
  input  wire logic                              last_cell,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [glpb_pkg::RISK_W-1:0]       risk_sum,
  output logic      [glpb_pkg::PROD_W-1:0]       basin_product,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [glpb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [glpb_pkg::CFG_DATA_W-1:0]   cfg_data
);
  localparam int CAP = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW  = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int NW  = $clog2(CAP + 1);
  localparam int CW  = NW;
  localparam int XW  = $clog2(MAX_WIDTH + 1);
  localparam int YW  = $clog2(MAX_HEIGHT + 1);
  localparam int KW  = $clog2(TOP_COUNT + 1);
  localparam int HW  = glpb_pkg::HEIGHT_W;

  typedef enum logic [3:0] {
    S_CLEAR, S_LOAD, S_FETCH, S_EVAL, S_CNT_RD, S_CNT_WR, S_SCAN, S_MUL, S_DONE
  } state_t;

  state_t state;
  logic [glpb_pkg::CFG_DATA_W-1:0] grid_width, grid_height;
  logic [NW-1:0] load_pos;
  logic [NW-1:0] clr_cnt;
  logic [AW-1:0] p, cur;
  logic [XW-1:0] px, cx;
  logic [YW-1:0] py, cy;
  logic          first;
  logic [2:0]    fk;
  logic [HW-1:0] hv [5];
  logic [glpb_pkg::RISK_W-1:0] risk;
  logic [CW-1:0] top [TOP_COUNT];
  logic [NW-1:0] scan_q;
  logic          scan_v;
  logic [AW-1:0] scan_a;
  logic [KW-1:0] mk;
  logic [glpb_pkg::PROD_W-1:0] prod;

  // effective map size
  logic [XW-1:0] w_eff;
  logic [YW-1:0] h_eff;
  logic [NW-1:0] n_cells;
  always_comb begin
    if (grid_width == '0) w_eff = XW'(1);
    else if (int'(grid_width) > MAX_WIDTH) w_eff = XW'(MAX_WIDTH);
    else w_eff = XW'(grid_width);
    if (grid_height == '0) h_eff = YW'(1);
    else if (int'(grid_height) > MAX_HEIGHT) h_eff = YW'(MAX_HEIGHT);
    else h_eff = YW'(grid_height);
  end
  assign n_cells = NW'(w_eff * h_eff);

  assign in_ready  = (state == S_LOAD);
  assign cfg_ready = 1'b1;

  // saturated input height
  logic [HW-1:0] hin;
  assign hin = (cell_height > glpb_pkg::BORDER_HEIGHT) ? glpb_pkg::BORDER_HEIGHT : cell_height;

  // neighbour addresses and border flags of the current walk cell
  logic [AW-1:0] nidx [5];
  logic          nval [5];
  assign nidx[0] = cur;
  assign nidx[1] = cur - AW'(1);
  assign nidx[2] = cur + AW'(1);
  assign nidx[3] = cur - AW'(w_eff);
  assign nidx[4] = cur + AW'(w_eff);
  assign nval[0] = 1'b1;
  assign nval[1] = (cx != '0);
  assign nval[2] = (cx != w_eff - XW'(1));
  assign nval[3] = (cy != '0);
  assign nval[4] = (cy != h_eff - YW'(1));

  // low point test and first lower neighbour
  logic [HW-1:0] nb [1:4];
  logic          is_low, found;
  logic [2:0]    dir;
  always_comb begin
    is_low = 1'b1;
    found  = 1'b0;
    dir    = 3'd1;
    for (int k = 1; k <= 4; k++) begin
      nb[k] = nval[k] ? hv[k] : glpb_pkg::BORDER_HEIGHT;
      if (!(hv[0] < nb[k])) is_low = 1'b0;
      if (!found && nb[k] < hv[0]) begin
        found = 1'b1;
        dir   = 3'(k);
      end
    end
  end

  // height RAM
  logic [HW-1:0] h_rdata;
  logic [AW-1:0] h_raddr;
  assign h_raddr = nidx[fk[2:0] > 3'd4 ? 3'd0 : fk];
  glpb_ram #(.WIDTH(HW), .DEPTH(CAP), .ADDR_W(AW)) u_height_ram (
    .clk   (clk),
    .we    (in_valid && in_ready && (load_pos < n_cells)),
    .waddr (load_pos[AW-1:0]),
    .wdata (hin),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  // basin count RAM, cleared by sweep after reset and by the final scan
  logic [CW-1:0] c_rdata, c_wdata;
  logic [AW-1:0] c_waddr, c_raddr;
  logic          c_we;
  always_comb begin
    c_we    = 1'b0;
    c_waddr = cur;
    c_wdata = c_rdata + CW'(1);
    c_raddr = (state == S_SCAN) ? scan_q[AW-1:0] : cur;
    case (state)
      S_CLEAR: begin
        c_we    = 1'b1;
        c_waddr = clr_cnt[AW-1:0];
        c_wdata = '0;
      end
      S_CNT_WR: c_we = 1'b1;
      S_SCAN: begin
        c_we    = scan_v;
        c_waddr = scan_a;
        c_wdata = '0;
      end
      default: c_we = 1'b0;
    endcase
  end
  glpb_ram #(.WIDTH(CW), .DEPTH(CAP), .ADDR_W(AW)) u_count_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  // insertion of one count into the largest list
  logic [CW-1:0] top_next [TOP_COUNT];
  logic [CW-1:0] ins_v, ins_t;
  always_comb begin
    ins_v = c_rdata;
    for (int k = 0; k < TOP_COUNT; k++) begin
      if (ins_v > top[k]) begin
        ins_t       = top[k];
        top_next[k] = ins_v;
        ins_v       = ins_t;
      end else begin
        ins_t       = ins_v;
        top_next[k] = top[k];
      end
    end
  end

  logic [CW-1:0] factor;
  assign factor = (top[mk[KW-1:0] >= KW'(TOP_COUNT) ? '0 : mk] == '0) ? CW'(1)
                  : top[mk[KW-1:0] >= KW'(TOP_COUNT) ? '0 : mk];

  logic last_p;
  assign last_p = (NW'(p) + NW'(1) == n_cells);

  // sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      grid_width  <= 8'd128;
      grid_height <= 8'd128;
      load_pos    <= '0;
      clr_cnt     <= '0;
      out_valid   <= 1'b0;
      scan_v      <= 1'b0;
      fk          <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          glpb_pkg::REG_GRID_WIDTH:  grid_width  <= cfg_data;
          glpb_pkg::REG_GRID_HEIGHT: grid_height <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) out_valid <= 1'b0;

      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + NW'(1);
          if (clr_cnt == NW'(CAP - 1)) state <= S_LOAD;
        end
        S_LOAD: begin
          if (in_valid) begin
            if (load_pos < n_cells) load_pos <= load_pos + NW'(1);
            if (last_cell) begin
              load_pos <= '0;
              p        <= '0;
              px       <= '0;
              py       <= '0;
              cur      <= '0;
              cx       <= '0;
              cy       <= '0;
              first    <= 1'b1;
              fk       <= '0;
              risk     <= '0;
              for (int k = 0; k < TOP_COUNT; k++) top[k] <= '0;
              state    <= S_FETCH;
            end
          end
        end
        // five reads: centre, left, right, up, down
        S_FETCH: begin
          fk <= fk + 3'd1;
          if (fk != 3'd0) hv[fk - 3'd1] <= h_rdata;
          if (fk == 3'd5) state <= S_EVAL;
        end
        S_EVAL: begin
          fk    <= '0;
          first <= 1'b0;
          if (first && is_low) risk <= risk + glpb_pkg::RISK_W'(hv[0]) + glpb_pkg::RISK_W'(1);
          if (first && hv[0] >= glpb_pkg::BORDER_HEIGHT) begin
            if (last_p) begin
              scan_q <= '0;
              scan_v <= 1'b0;
              state  <= S_SCAN;
            end else begin
              p     <= p + AW'(1);
              cur   <= p + AW'(1);
              first <= 1'b1;
              if (px == w_eff - XW'(1)) begin
                px <= '0;
                py <= py + YW'(1);
                cx <= '0;
                cy <= py + YW'(1);
              end else begin
                px <= px + XW'(1);
                cx <= px + XW'(1);
                cy <= py;
              end
              state <= S_FETCH;
            end
          end else if (found) begin
            cur <= nidx[dir];
            case (dir)
              3'd1: cx <= cx - XW'(1);
              3'd2: cx <= cx + XW'(1);
              3'd3: cy <= cy - YW'(1);
              default: cy <= cy + YW'(1);
            endcase
            state <= S_FETCH;
          end else begin
            state <= S_CNT_RD;
          end
        end
        S_CNT_RD: state <= S_CNT_WR;
        S_CNT_WR: begin
          if (last_p) begin
            scan_q <= '0;
            scan_v <= 1'b0;
            state  <= S_SCAN;
          end else begin
            p     <= p + AW'(1);
            cur   <= p + AW'(1);
            first <= 1'b1;
            if (px == w_eff - XW'(1)) begin
              px <= '0;
              py <= py + YW'(1);
              cx <= '0;
              cy <= py + YW'(1);
            end else begin
              px <= px + XW'(1);
              cx <= px + XW'(1);
              cy <= py;
            end
            state <= S_FETCH;
          end
        end
        // stream counts, keep the largest, zero each entry behind the read
        S_SCAN: begin
          scan_v <= (scan_q < n_cells);
          scan_a <= scan_q[AW-1:0];
          if (scan_q < n_cells) scan_q <= scan_q + NW'(1);
          if (scan_v) begin
            for (int k = 0; k < TOP_COUNT; k++) top[k] <= top_next[k];
          end
          if (!(scan_q < n_cells) && !scan_v) begin
            mk    <= '0;
            prod  <= glpb_pkg::PROD_W'(1);
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod <= glpb_pkg::PROD_W'(prod * factor);
          mk   <= mk + KW'(1);
          if (mk == KW'(TOP_COUNT - 1)) state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            risk_sum      <= risk;
            basin_product <= prod;
            state         <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // checks
  a_ready_only_loading: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (state == S_LOAD))
    else $error("input taken outside loading");
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result word raised outside finishing step");
  a_fetch_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH) |-> (fk <= 3'd5))
    else $error("fetch counter overran");
  a_walk_descends: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL && found && hv[0] < glpb_pkg::BORDER_HEIGHT)
      |=> (state == S_FETCH && fk == 3'd0))
    else $error("walk step did not start a fetch");
endmodule
`default_nettype wire
